// File: rtl/priority_queue_remove_max_assert.svh
// ----------------------------------------------------------------------------
// priority_queue_remove_max assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_REMOVE_MAX_ASSERT_SVH
`define PRIORITY_QUEUE_REMOVE_MAX_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PQRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define PQRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pqrm_pkg.sv
// ----------------------------------------------------------------------------
// pqrm_pkg
// Shared types and codes of the priority queue with removal of the maximum.
// ----------------------------------------------------------------------------
package pqrm_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int TAG_W  = 16;
    localparam int AGE_W  = 7;
    localparam int PRIO_W = 8;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_ENQ   = 2'd0;
    localparam status_t STATUS_DEQ   = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;
    localparam status_t STATUS_FULL  = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

// File: rtl/pqrm_ram.sv
// ----------------------------------------------------------------------------
// pqrm_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pqrm_ram #(
    parameter int DEPTH = pqrm_pkg::DEPTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  pqrm_pkg::entry_t                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output pqrm_pkg::entry_t                         rd_data
);

    pqrm_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/priority_queue_remove_max.sv
// Enqueue, and dequeue of an empty queue: result strobed in the cycle after the word is taken.
// Dequeue reads the entry store one word per cycle, first for the scan over every entry and
// then for the shift of the entries above the winner that closes the gap.
// busy is low again in the cycle the result is strobed, so the next word may start then.
// Reset empties the queue at once; entry contents are left as they are.
// ----------------------------------------------------------------------------
// priority_queue_remove_max
// Bounded priority queue in arrival order; removal scans for the highest
// priority (earliest wins ties) and shifts the later entries down.
// ----------------------------------------------------------------------------
`include "priority_queue_remove_max_assert.svh"

module priority_queue_remove_max #(
    parameter int DEPTH = pqrm_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [pqrm_pkg::TAG_W-1:0]    tag,
    input  logic [pqrm_pkg::AGE_W-1:0]    age,
    input  logic [pqrm_pkg::PRIO_W-1:0]   prio,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [pqrm_pkg::TAG_W-1:0]    out_tag,
    output logic [pqrm_pkg::AGE_W-1:0]    out_age,
    output logic [pqrm_pkg::PRIO_W-1:0]   out_prio
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    pqrm_pkg::entry_t       best_reg, best_next;
    logic                   done_reg, done_next;
    pqrm_pkg::status_t      status_reg, status_next;
    pqrm_pkg::entry_t       result_reg, result_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    pqrm_pkg::entry_t       wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    pqrm_pkg::entry_t       rd_data;

    logic [CNT_W-1:0]       count_m1;
    logic [IDX_W-1:0]       last_idx;
    logic                   take;
    logic [IDX_W-1:0]       cand_idx;
    logic                   accept;
    pqrm_pkg::entry_t       in_entry;
    logic                   enq_go;
    logic                   deq_go;

    pqrm_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept   = start && !busy;
    assign count_m1 = count_reg - 1'b1;
    assign last_idx = count_m1[IDX_W-1:0];
    assign in_entry = '{tag: tag, age: age, prio: prio};

    // first word of the scan seeds the best; strictly greater keeps the earliest on ties
    assign take     = (rd_idx_reg == '0) || (rd_data.prio > best_reg.prio);
    assign cand_idx = take ? rd_idx_reg : best_idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = in_entry;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    if (func == pqrm_pkg::OP_ENQ)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = pqrm_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = pqrm_pkg::STATUS_ENQ;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = pqrm_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (take)
                    begin
                        best_next     = rd_data;
                        best_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == last_idx)
                    begin
                        // shift starts with the slot just above the winner
                        ptr_next   = CNT_W'(cand_idx) + 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    // move each later word down one slot
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - 1'b1;
                    wr_data = rd_data;
                end
                if ((rd_valid_reg && (rd_idx_reg == last_idx)) ||
                    (!rd_valid_reg && (ptr_reg >= count_reg)))
                begin
                    count_next  = count_m1;
                    done_next   = 1'b1;
                    status_next = pqrm_pkg::STATUS_DEQ;
                    result_next = best_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign out_tag  = result_reg.tag;
    assign out_age  = result_reg.age;
    assign out_prio = result_reg.prio;

    assign enq_go = accept && (func == pqrm_pkg::OP_ENQ) && (count_reg != CNT_W'(DEPTH));
    assign deq_go = accept && (func == pqrm_pkg::OP_DEQ) && (count_reg != '0);

    `PQRM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `PQRM_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while still busy")
    `PQRM_ASSERT_NEXT(a_deq_busy, deq_go, busy, "dequeue did not start")
    `PQRM_ASSERT_NEXT(a_enq_count, enq_go, count_reg == $past(count_reg) + 1'b1, "fill not raised")

endmodule
